>>> rtl/core/cbf_pkg.sv
// Shared constants for the cubic Bezier flattener.
// No dependencies.
package cbf_pkg;

  localparam int FIELD_W         = 32;
  localparam int COORD_BITS_DEF  = 32;
  localparam int MAX_DEPTH_DEF   = 5;
  localparam int RATIO_FRAC      = 16;
  localparam int TOL_W           = 40;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(655);
  localparam int ERR_W           = 44;
  localparam logic [63:0] SAT_MAG = 64'd2097152;
  localparam logic [ERR_W-1:0] ERR_CAP = ERR_W'(64'd4398046511104);

endpackage

>>> rtl/core/cubic_bezier_flattener_unit.sv
// Cubic Bezier flattener: adaptive de Casteljau subdivision on one shared multiplier.
// Depends on cbf_pkg.
// Each tested subdivision node runs up to two ratio divisions plus multiplies; there are up to
// 2^MAX_DEPTH-1 tested nodes and 2^MAX_DEPTH depth-capped leaves per curve. Output stalls
// hold the sequencer; the next curve is taken only once the sequencer is back in idle after
// the last vertex beat is registered. All products share one multiply unit and the ratio
// divider is bit-serial. Reset (rst, synchronous) returns the sequencer to idle,
// drops any held output beat and loads tolerance_sq with 655.
module cubic_bezier_flattener_unit #(
  parameter int MAX_DEPTH  = cbf_pkg::MAX_DEPTH_DEF,
  parameter int COORD_BITS = cbf_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [cbf_pkg::FIELD_W-1:0] p0_x,
  input  logic signed [cbf_pkg::FIELD_W-1:0] p0_y,
  input  logic signed [cbf_pkg::FIELD_W-1:0] p1_x,
  input  logic signed [cbf_pkg::FIELD_W-1:0] p1_y,
  input  logic signed [cbf_pkg::FIELD_W-1:0] p2_x,
  input  logic signed [cbf_pkg::FIELD_W-1:0] p2_y,
  input  logic signed [cbf_pkg::FIELD_W-1:0] p3_x,
  input  logic signed [cbf_pkg::FIELD_W-1:0] p3_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cbf_pkg::FIELD_W-1:0] out_x,
  output logic signed [cbf_pkg::FIELD_W-1:0] out_y,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic        [cbf_pkg::TOL_W-1:0]   cfg_data
);
  import cbf_pkg::*;

  localparam int CW      = COORD_BITS;
  localparam int DW      = CW + 1;          // chord differences
  localparam int EW      = CW + 3;          // offsets after reduction, multiplier operands
  localparam int PW      = 2 * EW;          // raw product
  localparam int RW      = 2 * DW + 1;      // dot products and divider remainder
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W   = $clog2(RATIO_FRAC);

  typedef enum logic [4:0] {
    S_IDLE, S_TEST, S_V0, S_V1, S_V2, S_U0, S_U1, S_U2, S_UCHK, S_DIV,
    S_S0, S_S1, S_S2, S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_DEC, S_SPLIT,
    S_EMIT, S_FINAL
  } state_t;

  state_t state;

  // Segment under test, deferred second halves and their depths.
  logic signed [CW-1:0] s   [8];
  logic signed [CW-1:0] stk [MAX_DEPTH][8];
  logic [DEPTH_W-1:0]   stk_depth [MAX_DEPTH];
  logic [DEPTH_W-1:0]   sp;
  logic [DEPTH_W-1:0]   depth;
  logic signed [CW-1:0] last_x, last_y, end_x, end_y;
  logic [TOL_W-1:0]     tolerance_sq;

  // Error datapath.
  logic signed [EW-1:0] dx, dy, bx, by, cx, cy;
  logic signed [RW-1:0] u, v, rem;
  logic [RATIO_FRAC-1:0] r;
  logic [CNT_W-1:0]     cnt;
  logic                 sel;
  logic [ERR_W-1:0]     eb, ec;

  // Shared multiplier: operands picked by state, product registered.
  logic signed [EW-1:0] mul_a, mul_b, mag_a;
  logic signed [PW-1:0] prod;
  logic                 sat_q;

  logic signed [EW-1:0] ex, ey;
  assign ex = sel ? cx : bx;
  assign ey = sel ? cy : by;

  always_comb begin
    mul_a = dx;
    mul_b = dx;
    unique case (state)
      S_V1:          begin mul_a = dy; mul_b = dy; end
      S_U0:          begin mul_a = ex; mul_b = dx; end
      S_U1:          begin mul_a = ey; mul_b = dy; end
      S_S0:          begin mul_a = EW'(r); mul_b = dx; end
      S_S1:          begin mul_a = EW'(r); mul_b = dy; end
      S_Q0:          begin mul_a = bx; mul_b = bx; end
      S_Q1:          begin mul_a = by; mul_b = by; end
      S_Q2:          begin mul_a = cx; mul_b = cx; end
      S_Q3:          begin mul_a = cy; mul_b = cy; end
      default:       begin mul_a = dx; mul_b = dx; end
    endcase
    mag_a = mul_a[EW-1] ? -mul_a : mul_a;
  end

  always_ff @(posedge clk) begin
    prod  <= mul_a * mul_b;
    sat_q <= 64'(mag_a) >= SAT_MAG;
  end

  // Scaled chord component, truncated toward zero.
  logic signed [PW-1:0] prod_mag, prod_sh;
  logic signed [EW-1:0] trunc_q;
  always_comb begin
    prod_mag = prod[PW-1] ? -prod : prod;
    prod_sh  = prod_mag >>> RATIO_FRAC;
    trunc_q  = prod[PW-1] ? -EW'(prod_sh) : EW'(prod_sh);
  end

  // Saturated square.
  logic [ERR_W-1:0] sqv;
  assign sqv = sat_q ? ERR_CAP : ERR_W'(prod);

  // Restoring divider step.
  logic signed [RW-1:0] rem2;
  assign rem2 = rem <<< 1;

  // Midpoint subdivision.
  function automatic logic signed [CW-1:0] mid(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
    logic signed [CW:0] t;
    t = {a[CW-1], a} + {b[CW-1], b};
    return t[CW:1];
  endfunction

  logic signed [CW-1:0] abx, aby, bcx, bcy, cdx, cdy, m1x, m1y, m2x, m2y, fx, fy;
  always_comb begin
    abx = mid(s[0], s[2]);  aby = mid(s[1], s[3]);
    bcx = mid(s[2], s[4]);  bcy = mid(s[3], s[5]);
    cdx = mid(s[4], s[6]);  cdy = mid(s[5], s[7]);
    m1x = mid(abx, bcx);    m1y = mid(aby, bcy);
    m2x = mid(bcx, cdx);    m2y = mid(bcy, cdy);
    fx  = mid(m1x, m2x);    fy  = mid(m1y, m2y);
  end

  logic out_free;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // A new vertex beat is loaded into the output register this cycle.
  logic vtx_load;
  assign vtx_load = out_free &&
                    ((state == S_EMIT && !(s[0] == last_x && s[1] == last_y)) ||
                     (state == S_FINAL && !(end_x == last_x && end_y == last_y)));

  logic [IDX_W-1:0] push_idx, pop_idx;
  logic [DEPTH_W-1:0] sp_dec;
  assign sp_dec   = sp - DEPTH_W'(1);
  assign push_idx = sp[IDX_W-1:0];
  assign pop_idx  = sp_dec[IDX_W-1:0];

  logic [ERR_W-1:0] err_max;
  assign err_max = (eb > ec) ? eb : ec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      tolerance_sq <= TOL_RESET;
      sp           <= '0;
      depth        <= '0;
      sel          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) tolerance_sq <= cfg_data;
      // Drop the held beat once taken, unless a new one replaces it.
      if (out_valid && !out_stall && !vtx_load) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            s[0] <= p0_x[CW-1:0];  s[1] <= p0_y[CW-1:0];
            s[2] <= p1_x[CW-1:0];  s[3] <= p1_y[CW-1:0];
            s[4] <= p2_x[CW-1:0];  s[5] <= p2_y[CW-1:0];
            s[6] <= p3_x[CW-1:0];  s[7] <= p3_y[CW-1:0];
            end_x  <= p3_x[CW-1:0];
            end_y  <= p3_y[CW-1:0];
            last_x <= p0_x[CW-1:0];  // start point counts as emitted
            last_y <= p0_y[CW-1:0];
            sp     <= '0;
            depth  <= '0;
            state  <= S_TEST;
          end
        end
        S_TEST: begin
          dx  <= EW'(s[6]) - EW'(s[0]);
          dy  <= EW'(s[7]) - EW'(s[1]);
          bx  <= EW'(s[2]) - EW'(s[0]);
          by  <= EW'(s[3]) - EW'(s[1]);
          cx  <= EW'(s[4]) - EW'(s[0]);
          cy  <= EW'(s[5]) - EW'(s[1]);
          sel <= 1'b0;
          if (32'(depth) >= MAX_DEPTH) state <= S_EMIT;
          else if (s[6] == s[0] && s[7] == s[1]) state <= S_Q0;
          else state <= S_V0;
        end
        S_V0: state <= S_V1;
        S_V1: begin v <= RW'(prod); state <= S_V2; end
        S_V2: begin v <= v + RW'(prod); state <= S_U0; end
        S_U0: state <= S_U1;
        S_U1: begin u <= RW'(prod); state <= S_U2; end
        S_U2: begin u <= u + RW'(prod); state <= S_UCHK; end
        S_UCHK: begin
          if (u[RW-1] || u == '0) begin
            sel   <= 1'b1;
            state <= sel ? S_Q0 : S_U0;
          end else if (u >= v) begin
            if (sel) begin cx <= cx - dx; cy <= cy - dy; end
            else     begin bx <= bx - dx; by <= by - dy; end
            sel   <= 1'b1;
            state <= sel ? S_Q0 : S_U0;
          end else begin
            rem   <= u;
            r     <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem2 >= v) begin
            rem <= rem2 - v;
            r   <= {r[RATIO_FRAC-2:0], 1'b1};
          end else begin
            rem <= rem2;
            r   <= {r[RATIO_FRAC-2:0], 1'b0};
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(RATIO_FRAC - 1)) state <= S_S0;
        end
        S_S0: state <= S_S1;
        S_S1: begin
          if (sel) cx <= cx - trunc_q;
          else     bx <= bx - trunc_q;
          state <= S_S2;
        end
        S_S2: begin
          if (sel) cy <= cy - trunc_q;
          else     by <= by - trunc_q;
          sel   <= 1'b1;
          state <= sel ? S_Q0 : S_U0;
        end
        S_Q0: state <= S_Q1;
        S_Q1: begin eb <= sqv; state <= S_Q2; end
        S_Q2: begin eb <= eb + sqv; state <= S_Q3; end
        S_Q3: begin ec <= sqv; state <= S_Q4; end
        S_Q4: begin ec <= ec + sqv; state <= S_DEC; end
        S_DEC: state <= (err_max < ERR_W'(tolerance_sq)) ? S_EMIT : S_SPLIT;
        S_SPLIT: begin
          // Defer the second half, continue on the first.
          stk[push_idx][0] <= fx;   stk[push_idx][1] <= fy;
          stk[push_idx][2] <= m2x;  stk[push_idx][3] <= m2y;
          stk[push_idx][4] <= cdx;  stk[push_idx][5] <= cdy;
          stk[push_idx][6] <= s[6]; stk[push_idx][7] <= s[7];
          stk_depth[push_idx] <= depth + DEPTH_W'(1);
          sp    <= sp + DEPTH_W'(1);
          depth <= depth + DEPTH_W'(1);
          s[2] <= abx; s[3] <= aby; s[4] <= m1x; s[5] <= m1y;
          s[6] <= fx;  s[7] <= fy;
          state <= S_TEST;
        end
        S_EMIT: begin
          if ((s[0] == last_x && s[1] == last_y) || out_free) begin
            if (!(s[0] == last_x && s[1] == last_y)) begin
              out_valid <= 1'b1;
              out_x     <= FIELD_W'(s[0]);
              out_y     <= FIELD_W'(s[1]);
              out_last  <= 1'b0;
              last_x    <= s[0];
              last_y    <= s[1];
            end
            if (sp == '0) begin
              state <= S_FINAL;
            end else begin
              for (int i = 0; i < 8; i++) s[i] <= stk[pop_idx][i];
              depth <= stk_depth[pop_idx];
              sp    <= sp_dec;
              state <= S_TEST;
            end
          end
        end
        S_FINAL: begin
          if (end_x == last_x && end_y == last_y) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid <= 1'b1;
            out_x     <= FIELD_W'(end_x);
            out_y     <= FIELD_W'(end_y);
            out_last  <= 1'b1;
            last_x    <= end_x;
            last_y    <= end_y;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
